@@ rtl/binary_trie_max_xor_defines.svh @@
// Assertion macros for the binary trie max-xor RTL.
// Depends on nothing; included by btmx_ctrl, the only file that carries assertions.
`ifndef BINARY_TRIE_MAX_XOR_DEFINES_SVH
`define BINARY_TRIE_MAX_XOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BTMX_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BTMX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/btmx_pkg.sv @@
// Types, sizes and codes of the binary trie max-xor block.
// Depends on nothing; used by the controller and the top level.
package btmx_pkg;

  localparam int KEY_BITS   = 32;
  localparam int NODE_COUNT = 4096;
  localparam int COUNT_BITS = 16;

  localparam int LINK_BITS = $clog2(NODE_COUNT);
  localparam int FREE_BITS = LINK_BITS + 1;
  localparam int LVL_BITS  = $clog2(KEY_BITS);
  localparam int MISS_BITS = $clog2(KEY_BITS + 1);
  localparam int NODE_BITS = 2 * LINK_BITS + COUNT_BITS;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [LVL_BITS-1:0]   LVL_TOP = LVL_BITS'(KEY_BITS - 1);

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_ERASE  = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    logic [LINK_BITS-1:0]  link1;
    logic [LINK_BITS-1:0]  link0;
    logic [COUNT_BITS-1:0] cnt;
  } node_t;

  typedef struct packed {
    func_t         func;
    logic [31:0]   key;
  } req_t;

  typedef struct packed {
    status_t       status;
    logic [31:0]   best_xor;
  } res_t;

  typedef struct packed {
    logic                 we;
    logic [LINK_BITS-1:0] waddr;
    node_t                wdata;
    logic                 re;
    logic [LINK_BITS-1:0] raddr;
  } ram_cmd_t;

endpackage

@@ rtl/btmx_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
// Depends on nothing; holds the trie node pool.
module btmx_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 40,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/btmx_ctrl.sv @@
// Trie walk controller: check, update and query passes over the node RAM.
// Depends on btmx_pkg and binary_trie_max_xor_defines.svh.
`include "binary_trie_max_xor_defines.svh"
module btmx_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  btmx_pkg::req_t     req,
  output logic               idle,
  output logic               done,
  output btmx_pkg::res_t     res,
  input  logic               take,
  output btmx_pkg::ram_cmd_t ram,
  input  btmx_pkg::node_t    rdata
);
  import btmx_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_CHK  = 10'b0000000010,
    S_CAP  = 10'b0000000100,
    S_INS  = 10'b0000001000,
    S_INSR = 10'b0000010000,
    S_ERS  = 10'b0000100000,
    S_QA   = 10'b0001000000,
    S_QB   = 10'b0010000000,
    S_QC   = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  function automatic logic [LINK_BITS-1:0] child_of(node_t n, logic b);
    return b ? n.link1 : n.link0;
  endfunction

  function automatic node_t with_child(node_t n, logic b, logic [LINK_BITS-1:0] c);
    node_t r;
    r = n;
    if (b) begin
      r.link1 = c;
    end else begin
      r.link0 = c;
    end
    return r;
  endfunction

  state_t                state, state_next;
  func_t                 op, op_next;
  logic [31:0]           key, key_next;
  logic [LVL_BITS-1:0]   lvl, lvl_next;
  logic                  leaf, leaf_next;
  logic                  chk_cnt, chk_cnt_next;
  logic [MISS_BITS-1:0]  missing, missing_next;
  logic [LINK_BITS-1:0]  cur, cur_next;
  node_t                 cur_data, cur_data_next;
  logic                  incr, incr_next;
  logic [31:0]           ans, ans_next;
  status_t               status, status_next;
  logic [FREE_BITS-1:0]  next_free, next_free_next;
  logic [COUNT_BITS-1:0] live_total, live_total_next;
  logic                  root_valid, root_valid_next;
  logic                  rd_zero;

  node_t                 mnode;
  node_t                 node;
  logic                  b;
  logic [LINK_BITS-1:0]  c;
  logic [LINK_BITS-1:0]  c0;
  logic [FREE_BITS:0]    need;

  assign mnode = rd_zero ? '0 : rdata;
  assign b     = key[lvl];
  assign need  = {1'b0, next_free} + (FREE_BITS + 1)'(missing);

  always_comb begin
    state_next      = state;
    op_next         = op;
    key_next        = key;
    lvl_next        = lvl;
    leaf_next       = leaf;
    chk_cnt_next    = chk_cnt;
    missing_next    = missing;
    cur_next        = cur;
    cur_data_next   = cur_data;
    incr_next       = incr;
    ans_next        = ans;
    status_next     = status;
    next_free_next  = next_free;
    live_total_next = live_total;
    root_valid_next = root_valid;
    ram             = '0;
    node            = mnode;
    c               = '0;
    c0              = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next      = req.func;
          key_next     = req.key;
          ans_next     = '0;
          lvl_next     = LVL_TOP;
          leaf_next    = 1'b0;
          chk_cnt_next = 1'b0;
          missing_next = '0;
          cur_next     = '0;
          incr_next    = 1'b0;
          status_next  = ST_OK;
          if (req.func == FUNC_NONE) begin
            state_next = S_DONE;
          end else if (req.func == FUNC_QUERY && live_total == '0) begin
            status_next = ST_EMPTY;
            state_next  = S_DONE;
          end else if (req.func == FUNC_INSERT && live_total == CNT_MAX) begin
            status_next = ST_FULL;
            state_next  = S_DONE;
          end else begin
            ram.re     = 1'b1;
            ram.raddr  = '0;
            state_next = (req.func == FUNC_QUERY) ? S_QA : S_CHK;
          end
        end
      end

      S_CHK: begin
        c = child_of(mnode, b);
        if (chk_cnt && op == FUNC_INSERT && mnode.cnt == CNT_MAX) begin
          status_next = ST_FULL;
          state_next  = S_DONE;
        end else if (chk_cnt && op == FUNC_ERASE && mnode.cnt == '0) begin
          status_next = ST_ABSENT;
          state_next  = S_DONE;
        end else if (leaf) begin
          if (op == FUNC_INSERT) begin
            state_next = S_CAP;
          end else begin
            ram.re     = 1'b1;
            ram.raddr  = '0;
            lvl_next   = LVL_TOP;
            leaf_next  = 1'b0;
            cur_next   = '0;
            incr_next  = 1'b0;
            state_next = S_ERS;
          end
        end else if (c == '0) begin
          if (op == FUNC_INSERT) begin
            missing_next = MISS_BITS'({1'b0, lvl}) + 1'b1;
            state_next   = S_CAP;
          end else begin
            status_next = ST_ABSENT;
            state_next  = S_DONE;
          end
        end else begin
          ram.re       = 1'b1;
          ram.raddr    = c;
          chk_cnt_next = 1'b1;
          lvl_next     = (lvl == '0) ? lvl : lvl - 1'b1;
          leaf_next    = (lvl == '0);
        end
      end

      S_CAP: begin
        if (need > (FREE_BITS + 1)'(NODE_COUNT)) begin
          status_next = ST_FULL;
          state_next  = S_DONE;
        end else begin
          ram.re     = 1'b1;
          ram.raddr  = '0;
          lvl_next   = LVL_TOP;
          leaf_next  = 1'b0;
          cur_next   = '0;
          incr_next  = 1'b0;
          state_next = S_INS;
        end
      end

      S_INS, S_INSR: begin
        if (state == S_INSR) begin
          node = cur_data;
        end else begin
          node = mnode;
          if (incr) begin
            node.cnt = mnode.cnt + 1'b1;
          end
        end
        c         = child_of(node, b);
        ram.we    = 1'b1;
        ram.waddr = cur;
        ram.wdata = node;
        if (cur == '0) begin
          root_valid_next = 1'b1;
        end
        if (leaf) begin
          live_total_next = live_total + 1'b1;
          state_next      = S_DONE;
        end else begin
          lvl_next  = (lvl == '0) ? lvl : lvl - 1'b1;
          leaf_next = (lvl == '0);
          if (c == '0) begin
            ram.wdata      = with_child(node, b, next_free[LINK_BITS-1:0]);
            cur_data_next  = '{link1: '0, link0: '0, cnt: COUNT_BITS'(1)};
            cur_next       = next_free[LINK_BITS-1:0];
            next_free_next = next_free + 1'b1;
            state_next     = S_INSR;
          end else begin
            ram.re     = 1'b1;
            ram.raddr  = c;
            cur_next   = c;
            incr_next  = 1'b1;
            state_next = S_INS;
          end
        end
      end

      S_ERS: begin
        c = child_of(mnode, b);
        if (incr) begin
          ram.we        = 1'b1;
          ram.waddr     = cur;
          ram.wdata     = mnode;
          ram.wdata.cnt = mnode.cnt - 1'b1;
        end
        if (leaf) begin
          if (live_total != '0) begin
            live_total_next = live_total - 1'b1;
          end
          state_next = S_DONE;
        end else begin
          ram.re    = 1'b1;
          ram.raddr = c;
          cur_next  = c;
          incr_next = 1'b1;
          lvl_next  = (lvl == '0) ? lvl : lvl - 1'b1;
          leaf_next = (lvl == '0);
        end
      end

      S_QA, S_QC: begin
        node = (state == S_QC) ? cur_data : mnode;
        c    = child_of(node, ~b);
        c0   = child_of(node, b);
        if (leaf) begin
          state_next = S_DONE;
        end else if (c != '0) begin
          ram.re        = 1'b1;
          ram.raddr     = c;
          cur_data_next = node;
          state_next    = S_QB;
        end else if (c0 == '0) begin
          state_next = S_DONE;
        end else begin
          ram.re     = 1'b1;
          ram.raddr  = c0;
          lvl_next   = (lvl == '0) ? lvl : lvl - 1'b1;
          leaf_next  = (lvl == '0);
          state_next = S_QA;
        end
      end

      S_QB: begin
        c0 = child_of(cur_data, b);
        if (mnode.cnt != '0) begin
          ans_next[lvl] = 1'b1;
          cur_data_next = mnode;
          lvl_next      = (lvl == '0) ? lvl : lvl - 1'b1;
          leaf_next     = (lvl == '0);
          state_next    = S_QC;
        end else if (c0 == '0) begin
          state_next = S_DONE;
        end else begin
          ram.re     = 1'b1;
          ram.raddr  = c0;
          lvl_next   = (lvl == '0) ? lvl : lvl - 1'b1;
          leaf_next  = (lvl == '0);
          state_next = S_QA;
        end
      end

      S_DONE: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      next_free  <= FREE_BITS'(1);
      live_total <= '0;
      root_valid <= 1'b0;
      rd_zero    <= 1'b0;
    end else begin
      state      <= state_next;
      next_free  <= next_free_next;
      live_total <= live_total_next;
      root_valid <= root_valid_next;
      rd_zero    <= ram.re && ram.raddr == '0 && !root_valid;
    end
    op       <= op_next;
    key      <= key_next;
    lvl      <= lvl_next;
    leaf     <= leaf_next;
    chk_cnt  <= chk_cnt_next;
    missing  <= missing_next;
    cur      <= cur_next;
    cur_data <= cur_data_next;
    incr     <= incr_next;
    ans      <= ans_next;
    status   <= status_next;
  end

  assign idle         = (state == S_IDLE);
  assign done         = (state == S_DONE);
  assign res.status   = status;
  assign res.best_xor = ans;

  `BTMX_ASSERT_IMPL(a_free_bound, clk, rst, 1'b1, next_free <= FREE_BITS'(NODE_COUNT), "node pool pointer past end")
  `BTMX_ASSERT_IMPL(a_rw_apart, clk, rst, ram.we && ram.re, ram.waddr != ram.raddr, "read and write hit one node")
  `BTMX_ASSERT_IMPL(a_write_alloc, clk, rst, ram.we, {1'b0, ram.waddr} < next_free, "write to unallocated node")
  `BTMX_ASSERT_NEXT(a_total_step, clk, rst, 1'b1, live_total == $past(live_total) || live_total == $past(live_total) + 1'b1 || live_total == $past(live_total) - 1'b1, "key total jumped")
  `BTMX_ASSERT_IMPL(a_ans_query, clk, rst, state == S_DONE && op != FUNC_QUERY, ans == '0, "xor result on non-query")

endmodule

@@ rtl/binary_trie_max_xor.sv @@
// Binary trie max-xor block: multiset of 32-bit keys with max-xor queries.
// Request channel: req_valid, req_stall, func, key. A request is taken at a
// clock edge with req_valid high and req_stall low; func 0 inserts key, 1
// removes one copy, 2 returns the largest key XOR stored key, 3 does nothing.
// Response channel: rsp_valid, rsp_stall, status, best_xor; exactly one
// response per request, in order, held stable while rsp_stall is high.
// Requests are worked one at a time, each walk reading one trie level per
// access of the single node RAM. A request with nothing to walk goes straight
// to the done state once taken. A query takes up to 2 reads per level. A
// remove takes a 33-read check walk and a 33-read update walk. An insert
// takes a 33-read check walk, one pool check and up to 33 update steps.
// A finished response sits in the output register, so the next request is
// taken while it waits; a stalled response holds the controller after that.
// Reset is synchronous; it empties the set at once, with no clearing pass,
// and req_stall stays high while rst is high.
module binary_trie_max_xor (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  func,
  input  logic [31:0] key,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic [31:0] best_xor
);
  import btmx_pkg::*;

  logic     start;
  logic     idle;
  logic     done;
  logic     take;
  req_t     req;
  res_t     res;
  ram_cmd_t ram;
  node_t    rdata;

  assign req_stall = rst || !idle;
  assign start     = req_valid && !req_stall;
  assign req.func  = func_t'(func);
  assign req.key   = key;
  assign take      = !rsp_valid || !rsp_stall;

  btmx_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .idle  (idle),
    .done  (done),
    .res   (res),
    .take  (take),
    .ram   (ram),
    .rdata (rdata)
  );

  btmx_ram #(
    .DEPTH (NODE_COUNT),
    .WIDTH (NODE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .re    (ram.re),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done && take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (done && take) begin
      status   <= res.status;
      best_xor <= res.best_xor;
    end
  end

endmodule
